// ===== hdl/rfca_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the radio frame appender.
`default_nettype none
package rfca_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] CrcPoly  = 16'h8005;
  localparam logic [7:0]  PreSync  = 8'hAA;
  localparam logic [7:0]  PreLast  = 8'hA9;
  localparam logic [7:0]  LeadRst  = 8'h2A;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LOW   = 3'd0,
    CFG_KEY_MID   = 3'd1,
    CFG_KEY_HIGH  = 3'd2,
    CFG_NULL_ID   = 3'd3,
    CFG_NULL_SEED = 3'd4,
    CFG_LEAD      = 3'd5
  } cfg_idx_e;

  // Output byte sequence of one command
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SYNC1  = 3'd1,
    PH_SYNC2  = 3'd2,
    PH_SYNC3  = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_HI = 3'd5,
    PH_CRC_LO = 3'd6
  } phase_e;

  // One classified input word handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        last;
    logic [7:0]  lead;
    logic [15:0] crc;   // complemented CRC, valid when last is set
  } cmd_t;

  // CRC-16, poly 0x8005, MSB first, eight bit steps
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  byte_in);
    logic [15:0] crc;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      if (byte_in[i] ^ crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rfca_front.sv =====
// Front end: config registers, frame tracking, CRC update and command build.
`default_nettype none
module rfca_front import rfca_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                accept_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                last_byte_i,
  output cmd_t                     cmd_o
);

  logic [5:0]  key_low_q;
  logic [7:0]  key_mid_q;
  logic [7:0]  key_high_q;
  logic [5:0]  null_id_q;
  logic [15:0] null_seed_q;
  logic [7:0]  lead_q;

  logic [15:0] crc_q, crc_d;
  logic        in_frame_q, in_frame_d;

  logic [15:0] seed;
  logic [15:0] crc_next;
  logic [15:0] crc_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q   <= '0;
      key_mid_q   <= '0;
      key_high_q  <= '0;
      null_id_q   <= '0;
      null_seed_q <= '0;
      lead_q      <= LeadRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_LOW:   key_low_q   <= cfg_data_i[5:0];
        CFG_KEY_MID:   key_mid_q   <= cfg_data_i[7:0];
        CFG_KEY_HIGH:  key_high_q  <= cfg_data_i[7:0];
        CFG_NULL_ID:   null_id_q   <= cfg_data_i[5:0];
        CFG_NULL_SEED: null_seed_q <= cfg_data_i[15:0];
        CFG_LEAD:      lead_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!in_frame_q) begin
      seed = (key_low_q != null_id_q) ? {key_mid_q, key_high_q} : null_seed_q;
    end else begin
      seed = crc_q;
    end
    crc_next  = crc16_update(seed, data_byte_i);
    crc_final = ~crc_next;

    crc_d      = crc_q;
    in_frame_d = in_frame_q;
    if (accept_i) begin
      crc_d      = last_byte_i ? crc_final : crc_next;
      in_frame_d = !last_byte_i;
    end

    cmd_o.data  = data_byte_i;
    cmd_o.start = !in_frame_q;
    cmd_o.last  = last_byte_i;
    cmd_o.lead  = lead_q;
    cmd_o.crc   = crc_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= '0;
      in_frame_q <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      in_frame_q <= in_frame_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rfca_cmd_fifo.sv =====
// Small command queue between front and back.
`default_nettype none
module rfca_cmd_fifo import rfca_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  cmd_t      wr_data_i,
  output logic      full_o,
  input  wire logic rd_i,
  output cmd_t      rd_data_o,
  output logic      empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rfca_back.sv =====
// Back end: expands each command into frame bytes through an output register.
`default_nettype none
module rfca_back import rfca_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      cmd_i,
  input  wire logic cmd_empty_i,
  output logic      cmd_rd_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output logic [7:0] out_byte_o,
  output logic      out_last_o
);

  phase_e     phase_q, phase_d, cur_phase;
  logic       busy_q, busy_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       load;
  logic       done;

  always_comb begin
    load = !cmd_empty_i && (!out_valid_q || pop_i);
    cur_phase = busy_q ? phase_q : (cmd_i.start ? PH_LEAD : PH_DATA);

    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    done       = 1'b0;
    phase_d    = phase_q;
    unique case (cur_phase)
      PH_LEAD:   begin out_byte_d = cmd_i.lead;       phase_d = PH_SYNC1; end
      PH_SYNC1:  begin out_byte_d = PreSync;          phase_d = PH_SYNC2; end
      PH_SYNC2:  begin out_byte_d = PreSync;          phase_d = PH_SYNC3; end
      PH_SYNC3:  begin out_byte_d = PreLast;          phase_d = PH_DATA;  end
      PH_DATA:   begin
        out_byte_d = cmd_i.data;
        phase_d    = PH_CRC_HI;
        done       = !cmd_i.last;
      end
      PH_CRC_HI: begin out_byte_d = cmd_i.crc[15:8];  phase_d = PH_CRC_LO; end
      PH_CRC_LO: begin out_byte_d = cmd_i.crc[7:0];   done = 1'b1; end
      default:   begin out_byte_d = cmd_i.data;       done = 1'b1; end
    endcase
    out_last_d = (cur_phase == PH_CRC_LO);

    if (!load) begin
      out_byte_d = out_byte_q;
      out_last_d = out_last_q;
      phase_d    = phase_q;
    end

    busy_d = busy_q;
    if (load) begin
      busy_d = !done;
    end

    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end

    cmd_rd_o = load && done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/radio_frame_crc16_appender_top.sv =====
// Radio frame appender: preamble, payload pass-through and CRC-16 trailer.
//
// Input side is a queue: a payload word is taken on push while full is low.
// The front end updates the CRC (poly 0x8005, MSB first) in the same cycle
// and stores a command in a CmdDepth-entry queue. The back end turns each
// command into 1 to 7 output words: a four-word preamble when the word opens
// a frame, the payload word, and the complemented CRC (high, then low, the
// low one flagged out_last_o) after the word marked last.
// Output side is a queue too: the oldest word is shown while empty is low
// and taken on pop. One output word leaves per cycle from a registered
// stage while the receiver keeps popping; a taken input word is first
// written into the command queue, and the back end then loads its output
// words one by one into the output register. A stalled receiver
// holds the output stage, the command queue fills and full rises; nothing
// is dropped.
// Config writes (cfg_ready_o is always high) are meant for idle periods;
// the seed and the lead byte are sampled at each frame start.
// Reset clears the CRC, closes any open frame, empties both queues and sets
// the lead byte to 0x2A and all key registers to zero.
`default_nettype none
module radio_frame_crc16_appender_top import rfca_pkg::*; #(
  parameter int unsigned CmdDepth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                last_byte_i,
  input  wire logic                pop,
  output logic                     empty,
  output logic [7:0]               out_byte_o,
  output logic                     out_last_o
);

  cmd_t wr_cmd, rd_cmd;
  logic accept;
  logic cmd_empty;
  logic cmd_rd;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  rfca_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cmd_o       (wr_cmd)
  );

  rfca_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (wr_cmd),
    .full_o    (full),
    .rd_i      (cmd_rd),
    .rd_data_o (rd_cmd),
    .empty_o   (cmd_empty)
  );

  rfca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (rd_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_rd_o    (cmd_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the radio frame appender: queued stimulus, CRC-16 framing predictor, checks.
`timescale 1ns / 1ps
module testbench;
  import rfca_pkg::*;

  localparam logic [CfgIdxW-1:0] IdxUnusedA = 3'd6;
  localparam logic [CfgIdxW-1:0] IdxUnusedB = 3'd7;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_t;

  typedef struct packed {
    logic [7:0] value;
    logic       ends;
  } frame_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          data_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                pop = 1'b0;
  logic                empty;
  logic [7:0]          out_byte_o;
  logic                out_last_o;

  // register mirror
  logic [5:0]  key_low_r = '0;
  logic [7:0]  key_mid_r = '0;
  logic [7:0]  key_high_r = '0;
  logic [5:0]  null_id_r = '0;
  logic [15:0] null_seed_r = '0;
  logic [7:0]  lead_r = LeadRst;

  logic [15:0] crc_run = '0;
  logic        frame_open = 1'b0;

  payload_t    pending[$];
  frame_word_t frame_q[$];
  payload_t    tx_next;
  frame_word_t rx_want;
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned n_errors = 0;
  int unsigned stall_cnt = 0;
  logic        calm = 1'b0;
  logic        hold_rx = 1'b0;

  radio_frame_crc16_appender_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .pop         (pop),
    .empty       (empty),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // byte-wise fold: xor into the top byte, then eight shifts
  function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CrcPoly) : {r[14:0], 1'b0};
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    if (n_errors < 50) $display("rfca mismatch: %s", msg);
    n_errors++;
  endtask

  task automatic frame_word(input logic [7:0] v, input logic e);
    frame_q.push_back('{value: v, ends: e});
  endtask

  task automatic predict_frame_words(input logic [7:0] d, input logic l);
    if (!frame_open) begin
      frame_word(lead_r, 1'b0);
      frame_word(PreSync, 1'b0);
      frame_word(PreSync, 1'b0);
      frame_word(PreLast, 1'b0);
      crc_run = (key_low_r != null_id_r) ? {key_mid_r, key_high_r} : null_seed_r;
      frame_open = 1'b1;
    end
    frame_word(d, 1'b0);
    crc_run = crc16_fold(crc_run, d);
    if (l) begin
      crc_run = ~crc_run;
      frame_word(crc_run[15:8], 1'b0);
      frame_word(crc_run[7:0], 1'b1);
      frame_open = 1'b0;
    end
  endtask

  // sender: holds a word until taken, idles now and then
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_frame_words(data_byte_i, last_byte_i);
        n_taken++;
      end
      if (!push || !full) begin
        if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
          tx_next = pending.pop_front();
          push <= 1'b1;
          data_byte_i <= tx_next.data;
          last_byte_i <= tx_next.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (frame_q.size() == 0) begin
          log_mismatch($sformatf("unexpected word %02h last %0b", out_byte_o, out_last_o));
        end else begin
          rx_want = frame_q.pop_front();
          if (out_byte_o !== rx_want.value)
            log_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, rx_want.value));
          if (out_last_o !== rx_want.ends)
            log_mismatch($sformatf("out_last %0b, want %0b", out_last_o, rx_want.ends));
        end
      end
      pop <= !hold_rx && (calm || $urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic queue_word(input logic [7:0] d, input logic l);
    pending.push_back('{data: d, last: l});
    n_queued++;
  endtask

  task automatic queue_frame(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++) queue_word(8'($urandom), i == len);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_KEY_LOW:   key_low_r = val[5:0];
      CFG_KEY_MID:   key_mid_r = val[7:0];
      CFG_KEY_HIGH:  key_high_r = val[7:0];
      CFG_NULL_ID:   null_id_r = val[5:0];
      CFG_NULL_SEED: null_seed_r = val;
      CFG_LEAD:      lead_r = val[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic shuffle_settings();
    write_reg(CFG_KEY_LOW, pick16());
    write_reg(CFG_KEY_MID, pick16());
    write_reg(CFG_KEY_HIGH, pick16());
    write_reg(CFG_NULL_ID, pick16());
    write_reg(CFG_NULL_SEED, pick16());
    write_reg(CFG_LEAD, $urandom_range(0, 1) ? 16'h00AA : pick16());
    // a matching key id is rare by chance, so force it now and then
    if ($urandom_range(0, 2) == 0) write_reg(CFG_KEY_LOW, {10'd0, null_id_r});
    if ($urandom_range(0, 3) == 0) write_reg($urandom_range(0, 1) ? IdxUnusedA : IdxUnusedB,
                                             16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every word to be taken and every result to come back
  task automatic drain();
    while (n_taken != n_queued || frame_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n_goal;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: null key, zero seed, default lead
    queue_word(8'h00, 1'b1);
    queue_word(8'hFF, 1'b1);
    queue_word(8'h00, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_word(8'h80, 1'b0);
    queue_word(8'h01, 1'b0);
    queue_word(8'h55, 1'b0);
    queue_word(8'hAA, 1'b1);
    drain();

    write_reg(CFG_KEY_LOW, 16'hFFFF);
    write_reg(CFG_KEY_MID, 16'hFFFF);
    write_reg(CFG_KEY_HIGH, 16'h0000);
    write_reg(CFG_NULL_ID, 16'h0000);
    write_reg(CFG_NULL_SEED, 16'h0029);
    write_reg(CFG_LEAD, 16'h00AA);
    write_reg(IdxUnusedA, 16'hFFFF);
    write_reg(IdxUnusedB, 16'h5A5A);
    cfg_valid_i <= 1'b0;
    queue_word(8'h12, 1'b0);
    queue_word(8'h34, 1'b1);
    // leave a frame open across the next settings change
    queue_word(8'hFF, 1'b0);
    queue_word(8'h00, 1'b0);
    drain();

    write_reg(CFG_NULL_ID, 16'hFFFF);
    write_reg(CFG_NULL_SEED, 16'hFFFF);
    write_reg(CFG_LEAD, 16'h00FF);
    write_reg(CFG_KEY_MID, 16'h0000);
    write_reg(CFG_KEY_HIGH, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    queue_word(8'h7E, 1'b1);
    queue_word(8'h01, 1'b1);
    queue_word(8'hC3, 1'b0);
    queue_word(8'h3C, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      shuffle_settings();
      calm <= (ph == 2);
      n_goal = n_queued + 50;
      while (n_queued < n_goal)
        queue_frame(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 16));
      if ($urandom_range(0, 2) == 0) queue_frame(0 + $urandom_range(1, 3) + 0 * 0 + 0);
      if ($urandom_range(0, 1) == 1) begin
        queue_word(8'($urandom), 1'b0);
        queue_word(8'($urandom), 1'b0);
      end
      if (ph == 4) begin
        // receiver stalls while the sender keeps offering words
        hold_rx <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
    end

    drain();
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
